### rtl/core/chained_hash_intern_table_defines.svh
// Assertion macros shared by the hash intern table RTL.
`ifndef CHAINED_HASH_INTERN_TABLE_DEFINES_SVH
`define CHAINED_HASH_INTERN_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHIT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/chit_pkg.sv
// Types, codes and constants of the chained hash intern table.
package chit_pkg;

  // Storage geometry: entries, index and link widths, end-of-chain marker, size width and reset, hash bits.
  localparam int ENTRIES = 1024;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int LINK_W  = IDX_W + 1;
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(ENTRIES);
  localparam int SIZE_W  = 11;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1021);
  localparam int HASH_BITS = 31;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INTERN = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_UPDATE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STAT_FOUND       = 3'd0,
    STAT_INSERTED    = 3'd1,
    STAT_NOT_FOUND   = 3'd2,
    STAT_REMOVED     = 3'd3,
    STAT_UPDATED     = 3'd4,
    STAT_FULL        = 3'd5,
    STAT_REMOVE_MISS = 3'd6,
    STAT_RSVD        = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_HEAD, ST_HEADQ, ST_WALK, ST_CMP,
    ST_RELINK, ST_ALLOC, ST_FREEQ, ST_INSERT, ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] hash_code;
    logic [63:0] key_value;
    logic [31:0] handle;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] handle_out;
  } out_t;

endpackage

### rtl/core/chained_hash_intern_table.sv
// Chained hash intern table: 31-step bucket divider, chain walker and entry memories.
// The restoring divider forms the bucket index as the hash modulo the effective table size.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: synchronous; after reset a pass over all 1024 bucket heads clears them, stall high.
// Configuration writes are accepted at any time, including during that pass.
`include "chained_hash_intern_table_defines.svh"

module chained_hash_intern_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  chit_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output chit_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [chit_pkg::SIZE_W-1:0]    cfg_data
);

  // Memories.
  logic [chit_pkg::LINK_W-1:0] bucket_head  [chit_pkg::ENTRIES];
  logic [chit_pkg::LINK_W-1:0] entry_link   [chit_pkg::ENTRIES];
  logic [31:0]                 entry_hash   [chit_pkg::ENTRIES];
  logic [63:0]                 entry_key    [chit_pkg::ENTRIES];
  logic [31:0]                 entry_handle [chit_pkg::ENTRIES];

  // Control and working registers.
  chit_pkg::state_t            state, state_next;
  logic [chit_pkg::SIZE_W-1:0] table_size;
  logic [chit_pkg::SIZE_W-1:0] size;
  logic [1:0]                  req;
  logic [31:0]                 hash;
  logic [63:0]                 key;
  logic [31:0]                 hnd;
  logic [chit_pkg::SIZE_W-1:0] rem;
  logic [4:0]                  bit_cnt;
  logic [chit_pkg::LINK_W-1:0] cur, prev, ins_idx;
  logic [chit_pkg::LINK_W-1:0] steps;
  logic [chit_pkg::IDX_W-1:0]  clear_cnt;
  logic [chit_pkg::LINK_W-1:0] used_slots, free_head, free_slots;
  logic [2:0]                  res_status;
  logic [31:0]                 res_handle;

  // Registered memory read data.
  logic [chit_pkg::LINK_W-1:0] head_q, link_q;
  logic [31:0]                 hash_q, hnd_q;
  logic [63:0]                 key_q;

  // Combinational control.
  logic [chit_pkg::SIZE_W:0]    div_trial;
  logic                          div_ge;
  logic [chit_pkg::SIZE_W-1:0]  size_eff;
  logic                          hit;
  logic                          walk_end;
  logic                          from_free, from_used;
  logic [chit_pkg::IDX_W-1:0]   rd_addr;
  logic                          bh_we;
  logic [chit_pkg::IDX_W-1:0]   bh_waddr;
  logic [chit_pkg::LINK_W-1:0]  bh_wdata;
  logic                          lk_we;
  logic [chit_pkg::IDX_W-1:0]   lk_waddr;
  logic [chit_pkg::LINK_W-1:0]  lk_wdata;
  logic                          ins_we;
  logic                          hd_we;
  logic [chit_pkg::IDX_W-1:0]   hd_waddr;
  logic                          out_free;

  // Effective size clamps zero to one and anything above the entry count to it.
  always_comb begin
    if (table_size == '0) begin
      size_eff = chit_pkg::SIZE_W'(1);
    end else if (table_size > chit_pkg::SIZE_W'(chit_pkg::ENTRIES)) begin
      size_eff = chit_pkg::SIZE_W'(chit_pkg::ENTRIES);
    end else begin
      size_eff = table_size;
    end
  end

  // One restoring division step per cycle, most significant hash bit first.
  assign div_trial = {rem, hash[bit_cnt]};
  assign div_ge    = div_trial >= {1'b0, size};

  assign walk_end  = (cur >= chit_pkg::END_MARK) ||
                     (steps == chit_pkg::LINK_W'(chit_pkg::ENTRIES));
  assign hit       = (req == chit_pkg::REQ_REMOVE) ? (hnd_q == hnd) :
                     ((hash_q == hash) && (key_q == key));
  assign from_free = (free_slots != '0) && (free_head < chit_pkg::END_MARK);
  assign from_used = used_slots < size;
  assign rd_addr   = (state == chit_pkg::ST_ALLOC) ? free_head[chit_pkg::IDX_W-1:0] :
                                                     cur[chit_pkg::IDX_W-1:0];
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != chit_pkg::ST_IDLE);

  // Next state and memory write controls.
  always_comb begin
    state_next = state;
    bh_we      = 1'b0;
    bh_waddr   = rem[chit_pkg::IDX_W-1:0];
    bh_wdata   = link_q;
    lk_we      = 1'b0;
    lk_waddr   = prev[chit_pkg::IDX_W-1:0];
    lk_wdata   = link_q;
    ins_we     = 1'b0;
    hd_we      = 1'b0;
    hd_waddr   = cur[chit_pkg::IDX_W-1:0];
    unique case (state)
      chit_pkg::ST_CLEAR: begin
        bh_we    = 1'b1;
        bh_waddr = clear_cnt;
        bh_wdata = chit_pkg::END_MARK;
        if (clear_cnt == '1) begin
          state_next = chit_pkg::ST_IDLE;
        end
      end
      chit_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = chit_pkg::ST_DIV;
        end
      end
      chit_pkg::ST_DIV: begin
        if (bit_cnt == '0) begin
          state_next = chit_pkg::ST_HEAD;
        end
      end
      chit_pkg::ST_HEAD:  state_next = chit_pkg::ST_HEADQ;
      chit_pkg::ST_HEADQ: state_next = chit_pkg::ST_WALK;
      chit_pkg::ST_WALK: begin
        if (!walk_end) begin
          state_next = chit_pkg::ST_CMP;
        end else if (req == chit_pkg::REQ_INTERN) begin
          state_next = chit_pkg::ST_ALLOC;
        end else begin
          state_next = chit_pkg::ST_DONE;
        end
      end
      chit_pkg::ST_CMP: begin
        if (!hit) begin
          state_next = chit_pkg::ST_WALK;
        end else if (req == chit_pkg::REQ_REMOVE) begin
          // Unlink: patch the predecessor or the bucket head.
          if (prev < chit_pkg::END_MARK) begin
            lk_we = 1'b1;
          end else begin
            bh_we = 1'b1;
          end
          state_next = chit_pkg::ST_RELINK;
        end else begin
          hd_we      = (req == chit_pkg::REQ_UPDATE);
          state_next = chit_pkg::ST_DONE;
        end
      end
      chit_pkg::ST_RELINK: begin
        lk_we      = 1'b1;
        lk_waddr   = cur[chit_pkg::IDX_W-1:0];
        lk_wdata   = free_head;
        state_next = chit_pkg::ST_DONE;
      end
      chit_pkg::ST_ALLOC: begin
        if (from_free) begin
          state_next = chit_pkg::ST_FREEQ;
        end else if (from_used) begin
          state_next = chit_pkg::ST_INSERT;
        end else begin
          state_next = chit_pkg::ST_DONE;
        end
      end
      chit_pkg::ST_FREEQ: state_next = chit_pkg::ST_INSERT;
      chit_pkg::ST_INSERT: begin
        // New entry goes to the chain head.
        lk_we      = 1'b1;
        lk_waddr   = ins_idx[chit_pkg::IDX_W-1:0];
        lk_wdata   = head_q;
        ins_we     = 1'b1;
        hd_we      = 1'b1;
        hd_waddr   = ins_idx[chit_pkg::IDX_W-1:0];
        bh_we      = 1'b1;
        bh_wdata   = ins_idx;
        state_next = chit_pkg::ST_DONE;
      end
      chit_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = chit_pkg::ST_IDLE;
        end
      end
      default: state_next = chit_pkg::ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chit_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Memories: at most one write and one registered read per array each cycle.
  always_ff @(posedge clk) begin
    if (bh_we) begin
      bucket_head[bh_waddr] <= bh_wdata;
    end
    if (lk_we) begin
      entry_link[lk_waddr] <= lk_wdata;
    end
    if (ins_we) begin
      entry_hash[ins_idx[chit_pkg::IDX_W-1:0]] <= hash;
      entry_key[ins_idx[chit_pkg::IDX_W-1:0]]  <= key;
    end
    if (hd_we) begin
      entry_handle[hd_waddr] <= hnd;
    end
    head_q <= bucket_head[rem[chit_pkg::IDX_W-1:0]];
    link_q <= entry_link[rd_addr];
    hash_q <= entry_hash[rd_addr];
    key_q  <= entry_key[rd_addr];
    hnd_q  <= entry_handle[rd_addr];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= chit_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      table_size <= cfg_data;
    end
  end

  // Table bookkeeping and output beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt  <= '0;
      used_slots <= '0;
      free_head  <= chit_pkg::END_MARK;
      free_slots <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == chit_pkg::ST_CLEAR) begin
        clear_cnt <= clear_cnt + 1'b1;
      end
      // A new result beat replaces one that leaves in the same cycle.
      if (state == chit_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        chit_pkg::ST_RELINK: begin
          free_head  <= cur;
          free_slots <= free_slots + 1'b1;
        end
        chit_pkg::ST_ALLOC: begin
          if (!from_free && from_used) begin
            used_slots <= used_slots + 1'b1;
          end
        end
        chit_pkg::ST_FREEQ: begin
          free_head  <= link_q;
          free_slots <= free_slots - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    unique case (state)
      chit_pkg::ST_IDLE: begin
        req     <= in_data.req_type;
        hash    <= {1'b0, in_data.hash_code[chit_pkg::HASH_BITS-1:0]};
        key     <= in_data.key_value;
        hnd     <= in_data.handle;
        size    <= size_eff;
        rem     <= '0;
        bit_cnt <= 5'(chit_pkg::HASH_BITS - 1);
      end
      chit_pkg::ST_DIV: begin
        rem     <= div_ge ? chit_pkg::SIZE_W'(div_trial - {1'b0, size}) :
                            div_trial[chit_pkg::SIZE_W-1:0];
        bit_cnt <= bit_cnt - 1'b1;
      end
      chit_pkg::ST_HEADQ: begin
        cur        <= head_q;
        prev       <= chit_pkg::END_MARK;
        steps      <= '0;
        res_status <= (req == chit_pkg::REQ_REMOVE) ? chit_pkg::STAT_REMOVE_MISS :
                                                      chit_pkg::STAT_NOT_FOUND;
        res_handle <= '0;
      end
      chit_pkg::ST_CMP: begin
        if (!hit) begin
          prev  <= cur;
          cur   <= link_q;
          steps <= steps + 1'b1;
        end else if (req == chit_pkg::REQ_REMOVE) begin
          res_status <= chit_pkg::STAT_REMOVED;
        end else if (req == chit_pkg::REQ_UPDATE) begin
          res_status <= chit_pkg::STAT_UPDATED;
        end else begin
          res_status <= chit_pkg::STAT_FOUND;
          res_handle <= hnd_q;
        end
      end
      chit_pkg::ST_ALLOC: begin
        ins_idx    <= from_free ? free_head : used_slots;
        res_status <= chit_pkg::STAT_FULL;
      end
      chit_pkg::ST_INSERT: begin
        res_status <= chit_pkg::STAT_INSERTED;
        res_handle <= hnd;
      end
      chit_pkg::ST_DONE: begin
        if (out_free) begin
          out_data.status     <= res_status;
          out_data.handle_out <= res_handle;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks.
  `CHIT_ASSERT_NEXT(a_accept_starts_div, in_valid && !in_stall, state == chit_pkg::ST_DIV, "accepted beat did not start the divider")
  `CHIT_ASSERT_SAME(a_free_list_count, 1'b1, (free_head == chit_pkg::END_MARK) == (free_slots == '0), "free list head and count disagree")
  `CHIT_ASSERT_SAME(a_used_bound, 1'b1, used_slots <= chit_pkg::LINK_W'(chit_pkg::ENTRIES), "used slot count beyond capacity")
  `CHIT_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

### tb/tb_chained_hash_intern_table.sv
// Testbench for the chained hash intern table: random and directed requests against a predictor.
`timescale 1ns / 1ps

module tb_chained_hash_intern_table;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int POOL_N         = 12;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  chit_pkg::in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  chit_pkg::out_t  out_data;
  logic  cfg_we;
  logic  [chit_pkg::SIZE_W-1:0] cfg_data;

  chained_hash_intern_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // Mirror of the table contents and registers.
  int          mirror_head [chit_pkg::ENTRIES];
  int          mirror_link [chit_pkg::ENTRIES];
  logic [31:0] mirror_hash [chit_pkg::ENTRIES];
  logic [63:0] mirror_key  [chit_pkg::ENTRIES];
  logic [31:0] mirror_hnd  [chit_pkg::ENTRIES];
  int          mirror_used;
  int          mirror_free_head;
  int          mirror_free_cnt;
  int          mirror_size;

  chit_pkg::in_t   request_q [$];
  chit_pkg::out_t  answer_q  [$];
  int    error_cnt;
  bit    quiet;
  int    answers_seen;

  // Per-phase pool of keys so that hits, updates and removes are common.
  logic [31:0] pool_hash [POOL_N];
  logic [63:0] pool_key  [POOL_N];
  logic [31:0] pool_hnd  [POOL_N];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int effective_size();
    if (mirror_size == 0) return 1;
    if (mirror_size > chit_pkg::ENTRIES) return chit_pkg::ENTRIES;
    return mirror_size;
  endfunction

  // Walks one bucket chain for a hash and key match; ENTRIES means none.
  function automatic int find_match(int bucket, logic [31:0] h, logic [63:0] k);
    int i;
    int steps;
    i = mirror_head[bucket];
    steps = 0;
    while (i < chit_pkg::ENTRIES && steps < chit_pkg::ENTRIES) begin
      if (mirror_hash[i] == h && mirror_key[i] == k) return i;
      i = mirror_link[i];
      steps++;
    end
    return chit_pkg::ENTRIES;
  endfunction

  // Applies one request to the mirror and returns the answer the table must give.
  function automatic chit_pkg::out_t intern_answer(chit_pkg::in_t it);
    chit_pkg::out_t res;
    logic [31:0] h;
    int          bucket;
    int          idx;
    int          prev;
    int          steps;
    int          sz;
    h = {1'b0, it.hash_code[30:0]};
    sz = effective_size();
    bucket = int'(h % sz);
    res.status = chit_pkg::STAT_NOT_FOUND;
    res.handle_out = '0;
    case (chit_pkg::req_t'(it.req_type))
      chit_pkg::REQ_LOOKUP, chit_pkg::REQ_INTERN: begin
        idx = find_match(bucket, h, it.key_value);
        if (idx < chit_pkg::ENTRIES) begin
          res.status = chit_pkg::STAT_FOUND;
          res.handle_out = mirror_hnd[idx];
        end else if (chit_pkg::req_t'(it.req_type) == chit_pkg::REQ_INTERN) begin
          if (mirror_free_cnt > 0 && mirror_free_head < chit_pkg::ENTRIES) begin
            idx = mirror_free_head;
            mirror_free_head = mirror_link[idx];
            mirror_free_cnt--;
          end else if (mirror_used < sz) begin
            idx = mirror_used;
            mirror_used++;
          end
          if (idx < chit_pkg::ENTRIES) begin
            mirror_link[idx] = mirror_head[bucket];
            mirror_hash[idx] = h;
            mirror_key[idx]  = it.key_value;
            mirror_hnd[idx]  = it.handle;
            mirror_head[bucket] = idx;
            res.status = chit_pkg::STAT_INSERTED;
            res.handle_out = it.handle;
          end else begin
            res.status = chit_pkg::STAT_FULL;
          end
        end
      end
      chit_pkg::REQ_REMOVE: begin
        prev = chit_pkg::ENTRIES;
        idx = mirror_head[bucket];
        steps = 0;
        res.status = chit_pkg::STAT_REMOVE_MISS;
        while (idx < chit_pkg::ENTRIES && steps < chit_pkg::ENTRIES) begin
          if (mirror_hnd[idx] == it.handle) begin
            if (prev < chit_pkg::ENTRIES) mirror_link[prev] = mirror_link[idx];
            else mirror_head[bucket] = mirror_link[idx];
            mirror_link[idx] = mirror_free_head;
            mirror_free_head = idx;
            if (mirror_free_cnt < 16'hFFFF) mirror_free_cnt++;
            res.status = chit_pkg::STAT_REMOVED;
            break;
          end
          prev = idx;
          idx = mirror_link[idx];
          steps++;
        end
      end
      default: begin
        idx = find_match(bucket, h, it.key_value);
        if (idx < chit_pkg::ENTRIES) begin
          mirror_hnd[idx] = it.handle;
          res.status = chit_pkg::STAT_UPDATED;
        end
      end
    endcase
    return res;
  endfunction

  task automatic queue_request(chit_pkg::req_t r, logic [31:0] h, logic [63:0] k,
                               logic [31:0] hnd);
    chit_pkg::in_t it;
    it.req_type = r;
    it.hash_code = h;
    it.key_value = k;
    it.handle = hnd;
    request_q.push_back(it);
  endtask

  // Mostly pool keys with random operations; the rest is fully random noise.
  task automatic queue_random_request();
    int   p;
    int   roll;
    chit_pkg::req_t r;
    logic [31:0] h;
    logic [63:0] k;
    logic [31:0] hnd;
    p = $urandom_range(0, POOL_N - 1);
    roll = $urandom_range(0, 99);
    if (roll < 40) r = chit_pkg::REQ_INTERN;
    else if (roll < 60) r = chit_pkg::REQ_LOOKUP;
    else if (roll < 80) r = chit_pkg::REQ_REMOVE;
    else r = chit_pkg::REQ_UPDATE;
    h = pool_hash[p];
    k = pool_key[p];
    hnd = pool_hnd[$urandom_range(0, POOL_N - 1)];
    if ($urandom_range(0, 9) == 0) h[31] = ~h[31];
    if ($urandom_range(0, 9) == 0) begin
      h = $urandom;
      k = {$urandom, $urandom};
      hnd = $urandom;
    end
    if (r == chit_pkg::REQ_UPDATE && $urandom_range(0, 1) == 0) pool_hnd[p] = hnd;
    queue_request(r, h, k, hnd);
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL_N; i++) begin
      pool_hash[i] = $urandom;
      pool_key[i]  = {$urandom, $urandom};
      pool_hnd[i]  = $urandom;
    end
  endtask

  // Waits until the table is idle, then writes the size register.
  task automatic write_size(int value);
    while (request_q.size() != 0 || answer_q.size() != 0 || in_valid) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= chit_pkg::SIZE_W'(value);
    @(posedge clk);
    mirror_size = value;
    cfg_we <= 1'b0;
  endtask

  // Request driver: presents beats from the queue with random idle bursts.
  int gap_left;
  always @(posedge clk) begin
    logic take_next;
    take_next = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        answer_q.push_back(intern_answer(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() != 0) begin
          take_next = 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 5);
        end
        in_valid <= take_next;
        if (take_next) in_data <= request_q.pop_front();
      end
    end
  end

  // Answer monitor: random stalls, one long hold-off, and field checks.
  int stall_left;
  bit hold_done;
  always @(posedge clk) begin
    chit_pkg::out_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        answers_seen++;
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual status %0d handle %h",
                   $time, out_data.status, out_data.handle_out);
          error_cnt++;
        end else begin
          want = answer_q.pop_front();
          if (out_data.status != want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_data.status);
            error_cnt++;
          end
          if (out_data.handle_out != want.handle_out) begin
            $display("%0t: handle mismatch, expected %h, actual %h",
                     $time, want.handle_out, out_data.handle_out);
            error_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!hold_done && answers_seen >= 300) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Watchdog on cycles with no beat accepted on either side.
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus sequence: reset, directed checks, then random phases at several sizes.
  initial begin
    int sizes [8];
    sizes = '{1, 0, 2047, 2, 1024, 17, 1021, 7};
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    error_cnt = 0;
    quiet = 1'b0;
    answers_seen = 0;
    for (int i = 0; i < chit_pkg::ENTRIES; i++) begin
      mirror_head[i] = chit_pkg::ENTRIES;
      mirror_link[i] = 0;
      mirror_hash[i] = '0;
      mirror_key[i] = '0;
      mirror_hnd[i] = '0;
    end
    mirror_used = 0;
    mirror_free_head = chit_pkg::ENTRIES;
    mirror_free_cnt = 0;
    mirror_size = chit_pkg::SIZE_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at size 3: misses, extremes, full table, free-list reuse.
    write_size(3);
    queue_request(chit_pkg::REQ_LOOKUP, 32'h0, 64'h0, 32'h0);
    queue_request(chit_pkg::REQ_INTERN, 32'h0, 64'h0, 32'h0);
    queue_request(chit_pkg::REQ_INTERN, 32'h0, 64'h0, 32'h1234);
    queue_request(chit_pkg::REQ_LOOKUP, 32'h8000_0000, 64'h0, 32'h0);
    queue_request(chit_pkg::REQ_INTERN, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  32'hFFFF_FFFF);
    queue_request(chit_pkg::REQ_INTERN, 32'h7FFF_FFFF, 64'h5555_AAAA_5555_AAAA,
                  32'hA5A5_5A5A);
    queue_request(chit_pkg::REQ_INTERN, 32'h3, 64'h3, 32'h3);
    queue_request(chit_pkg::REQ_UPDATE, 32'h0, 64'h0, 32'hDEAD_BEEF);
    queue_request(chit_pkg::REQ_UPDATE, 32'h1, 64'h1, 32'h1);
    queue_request(chit_pkg::REQ_LOOKUP, 32'h0, 64'h0, 32'h0);
    queue_request(chit_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 64'h0, 32'hFFFF_FFFF);
    queue_request(chit_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 64'h0, 32'hFFFF_FFFF);
    queue_request(chit_pkg::REQ_INTERN, 32'h3, 64'h3, 32'h3);
    queue_request(chit_pkg::REQ_LOOKUP, 32'h3, 64'h3, 32'h0);
    queue_request(chit_pkg::REQ_REMOVE, 32'h0, 64'h0, 32'hDEAD_BEEF);
    queue_request(chit_pkg::REQ_LOOKUP, 32'h0, 64'h0, 32'h0);
    queue_request(chit_pkg::REQ_INTERN, 32'h6, 64'h9, 32'h7);

    for (int ph = 0; ph < 8; ph++) begin
      write_size(sizes[ph]);
      if (ph == 7) quiet = 1'b1;
      refill_pool();
      for (int n = 0; n < 160; n++) queue_random_request();
    end

    while (request_q.size() != 0 || answer_q.size() != 0 || in_valid) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/chit_pkg.sv
rtl/core/chained_hash_intern_table.sv
tb/tb_chained_hash_intern_table.sv
